// ===== hw/rtl/sscomp_pkg.sv =====
// Shared types, codes and default sizes for the sparse set component table.
// Used by every module of the block but sscomp_ram; depends on nothing.
package sscomp_pkg;

  localparam int unsigned ENTITY_ID_W = 10;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned SLOT_OUT_W  = 8;
  localparam int unsigned COUNT_OUT_W = 9;

  localparam int unsigned DEF_MAX_ENTITIES   = 1024;
  localparam int unsigned DEF_CAPACITY       = 256;
  localparam int unsigned DEF_COMPONENT_BITS = 64;

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] MODE_LOOKUP  = 2'd0;
  localparam logic [1:0] MODE_EMPLACE = 2'd1;
  localparam logic [1:0] MODE_REMOVE  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_EMPLACE,
    OP_REMOVE,
    OP_REJECT
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    op_e                    op;
    logic [ENTITY_ID_W-1:0] entity_id;
    logic [DATA_W-1:0]      word;
  } cmd_t;

  typedef struct packed {
    status_e                status;
    logic [DATA_W-1:0]      read_data;
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic [COUNT_OUT_W-1:0] live_count;
  } res_t;

endpackage

// ===== hw/rtl/sscomp_ram.sv =====
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module sscomp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sscomp_front.sv =====
// Front end: takes words from the input queue port, classifies them and
// holds them in a short command queue. Depends on sscomp_pkg.
module sscomp_front #(
  parameter int unsigned MAX_ENTITIES = sscomp_pkg::DEF_MAX_ENTITIES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            mode_i,
  input  logic [sscomp_pkg::ENTITY_ID_W-1:0]    entity_id_i,
  input  logic [sscomp_pkg::DATA_W-1:0]         component_data_i,
  input  logic                                  clearing_i,
  output logic                                  cmd_valid_o,
  output sscomp_pkg::cmd_t                      cmd_o,
  input  logic                                  cmd_pop_i
);
  import sscomp_pkg::*;

  cmd_t                  q_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  push_ok;
  logic                  pop_ok;
  logic [31:0]           eid_ext;
  cmd_t                  cmd_in;

  assign full        = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH)) || clearing_i;
  assign push_ok     = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop_ok      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_ptr_q];
  assign eid_ext     = 32'(entity_id_i);

  always_comb begin
    cmd_in.entity_id = entity_id_i;
    cmd_in.word      = component_data_i;
    if (eid_ext >= 32'(MAX_ENTITIES)) begin
      cmd_in.op = OP_REJECT;
    end else begin
      unique case (mode_i)
        MODE_EMPLACE: cmd_in.op = OP_EMPLACE;
        MODE_REMOVE:  cmd_in.op = OP_REMOVE;
        default:      cmd_in.op = OP_LOOKUP;
      endcase
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/sscomp_back.sv =====
// Back end: sequencer over the slot map, dense store and owner table that
// carries out each command and holds the result word. Depends on sscomp_pkg
// and sscomp_ram.
module sscomp_back #(
  parameter int unsigned MAX_ENTITIES   = sscomp_pkg::DEF_MAX_ENTITIES,
  parameter int unsigned CAPACITY       = sscomp_pkg::DEF_CAPACITY,
  parameter int unsigned COMPONENT_BITS = sscomp_pkg::DEF_COMPONENT_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  sscomp_pkg::cmd_t cmd_i,
  output logic             cmd_pop_o,
  output logic             clearing_o,
  input  logic             pop,
  output logic             res_valid_o,
  output sscomp_pkg::res_t res_o
);
  import sscomp_pkg::*;

  localparam int unsigned EW = $clog2(MAX_ENTITIES);
  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = SW + 1;
  localparam logic [EW-1:0] LastEnt = EW'(MAX_ENTITIES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_DATA  = 3'd3;
  localparam logic [2:0] S_MOVE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [EW-1:0] clr_q, clr_d;
  logic [SW-1:0] slot_q, slot_d;
  cmd_t          cur_q, cur_d;
  res_t          res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic                      map_we;
  logic [EW-1:0]             map_waddr, map_raddr;
  logic [MW-1:0]             map_wdata, map_rdata;
  logic                      dense_we;
  logic [SW-1:0]             dense_waddr, dense_raddr;
  logic [COMPONENT_BITS-1:0] dense_wdata, dense_rdata;
  logic                      owner_we;
  logic [SW-1:0]             owner_waddr, owner_raddr;
  logic [EW-1:0]             owner_wdata, owner_rdata;

  logic [31:0]   in_eid_ext, cur_eid_ext;
  logic [EW-1:0] cur_idx;
  logic          m_valid;
  logic [SW-1:0] m_slot;
  logic          present;
  logic [CW-1:0] last_cnt;
  logic [SW-1:0] last_slot;
  logic [SW-1:0] fresh_slot;
  logic          take;

  sscomp_ram #(.WIDTH(MW), .DEPTH(MAX_ENTITIES)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  sscomp_ram #(.WIDTH(COMPONENT_BITS), .DEPTH(CAPACITY)) u_dense (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_waddr),
    .wdata_i (dense_wdata),
    .raddr_i (dense_raddr),
    .rdata_o (dense_rdata)
  );

  sscomp_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_owner (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .waddr_i (owner_waddr),
    .wdata_i (owner_wdata),
    .raddr_i (owner_raddr),
    .rdata_o (owner_rdata)
  );

  function automatic res_t mk_res(status_e st, logic [DATA_W-1:0] d,
                                  logic [31:0] s, logic [31:0] c);
    res_t r;
    r.status     = st;
    r.read_data  = d;
    r.slot_index = s[SLOT_OUT_W-1:0];
    r.live_count = c[COUNT_OUT_W-1:0];
    return r;
  endfunction

  assign in_eid_ext  = 32'(cmd_i.entity_id);
  assign cur_eid_ext = 32'(cur_q.entity_id);
  assign cur_idx     = cur_eid_ext[EW-1:0];
  assign m_valid     = map_rdata[MW-1];
  assign m_slot      = map_rdata[SW-1:0];
  assign present     = m_valid && (CW'(m_slot) < count_q);
  assign last_cnt    = count_q - 1'b1;
  assign last_slot   = last_cnt[SW-1:0];
  assign fresh_slot  = count_q[SW-1:0];
  assign take        = (state_q == S_IDLE) && cmd_valid_i && (!res_valid_q || pop);

  assign cmd_pop_o   = take;
  assign clearing_o  = (state_q == S_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop;

    map_we      = 1'b0;
    map_waddr   = cur_idx;
    map_wdata   = '0;
    map_raddr   = in_eid_ext[EW-1:0];
    dense_we    = 1'b0;
    dense_waddr = slot_q;
    dense_wdata = cur_q.word[COMPONENT_BITS-1:0];
    dense_raddr = m_slot;
    owner_we    = 1'b0;
    owner_waddr = fresh_slot;
    owner_wdata = cur_idx;
    owner_raddr = last_slot;

    unique case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastEnt) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          cur_d = cmd_i;
          if (cmd_i.op == OP_REJECT) begin
            res_d       = mk_res(ST_ABSENT, '0, 32'd0, 32'(count_q));
            res_valid_d = 1'b1;
          end else begin
            state_d = S_MAP;
          end
        end
      end
      S_MAP: begin
        state_d = S_IDLE;
        case (cur_q.op)
          OP_EMPLACE: begin
            res_valid_d = 1'b1;
            if (present) begin
              dense_we    = 1'b1;
              dense_waddr = m_slot;
              res_d       = mk_res(ST_OK, '0, 32'(m_slot), 32'(count_q));
            end else if (count_q == CW'(CAPACITY)) begin
              res_d = mk_res(ST_FULL, '0, 32'd0, 32'(count_q));
            end else begin
              dense_we    = 1'b1;
              dense_waddr = fresh_slot;
              owner_we    = 1'b1;
              map_we      = 1'b1;
              map_wdata   = {1'b1, fresh_slot};
              count_d     = count_q + 1'b1;
              res_d       = mk_res(ST_OK, '0, 32'(fresh_slot), 32'(count_d));
            end
          end
          OP_REMOVE: begin
            if (!present) begin
              res_valid_d = 1'b1;
              res_d       = mk_res(ST_ABSENT, '0, 32'd0, 32'(count_q));
            end else begin
              map_we  = 1'b1;
              count_d = last_cnt;
              if (m_slot == last_slot) begin
                res_valid_d = 1'b1;
                res_d       = mk_res(ST_OK, '0, 32'(m_slot), 32'(last_cnt));
              end else begin
                dense_raddr = last_slot;
                slot_d      = m_slot;
                state_d     = S_MOVE;
              end
            end
          end
          default: begin
            if (present) begin
              slot_d  = m_slot;
              state_d = S_DATA;
            end else begin
              res_valid_d = 1'b1;
              res_d       = mk_res(ST_ABSENT, '0, 32'd0, 32'(count_q));
            end
          end
        endcase
      end
      S_DATA: begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        res_d       = mk_res(ST_OK, DATA_W'(dense_rdata), 32'(slot_q), 32'(count_q));
      end
      S_MOVE: begin
        state_d     = S_IDLE;
        dense_we    = 1'b1;
        dense_wdata = dense_rdata;
        owner_we    = 1'b1;
        owner_waddr = slot_q;
        owner_wdata = owner_rdata;
        map_we      = 1'b1;
        map_waddr   = owner_rdata;
        map_wdata   = {1'b1, slot_q};
        res_valid_d = 1'b1;
        res_d       = mk_res(ST_OK, '0, 32'(slot_q), 32'(count_q));
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
  end

endmodule

// ===== hw/rtl/sparse_set_component_table.sv =====
// Top level of the sparse set component table: front end, command queue and
// back end sequencer. Depends on sscomp_pkg, sscomp_front and sscomp_back.
//
//   Channel   Handshake          Word
//   input     push / full        mode_i, entity_id_i, component_data_i
//   result    empty / pop        status_o, read_data_o, slot_index_o, live_count_o
//
// After reset the slot map is cleared one entry a cycle, and full stays high
// until that pass is done.
// The back end takes one command per pass through its sequencer: a rejected
// command ends in S_IDLE, a lookup hit passes S_MAP, S_DATA, a moving remove passes
// S_MAP, S_MOVE, the others S_MAP. The slot map and dense store reads set this.
// Two commands wait in the queue while a result waits to be popped.
module sparse_set_component_table #(
  parameter int unsigned MAX_ENTITIES   = sscomp_pkg::DEF_MAX_ENTITIES,
  parameter int unsigned CAPACITY       = sscomp_pkg::DEF_CAPACITY,
  parameter int unsigned COMPONENT_BITS = sscomp_pkg::DEF_COMPONENT_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            mode_i,
  input  logic [sscomp_pkg::ENTITY_ID_W-1:0]    entity_id_i,
  input  logic [sscomp_pkg::DATA_W-1:0]         component_data_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [1:0]                            status_o,
  output logic [sscomp_pkg::DATA_W-1:0]         read_data_o,
  output logic [sscomp_pkg::SLOT_OUT_W-1:0]     slot_index_o,
  output logic [sscomp_pkg::COUNT_OUT_W-1:0]    live_count_o
);
  import sscomp_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  logic clearing;
  logic res_valid;
  cmd_t cmd;
  res_t res;

  sscomp_front #(.MAX_ENTITIES(MAX_ENTITIES)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .entity_id_i      (entity_id_i),
    .component_data_i (component_data_i),
    .clearing_i       (clearing),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  sscomp_back #(
    .MAX_ENTITIES   (MAX_ENTITIES),
    .CAPACITY       (CAPACITY),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .pop         (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty        = !res_valid;
  assign status_o     = res.status;
  assign read_data_o  = res.read_data;
  assign slot_index_o = res.slot_index;
  assign live_count_o = res.live_count;

endmodule

// ===== tb/sv/tb_sparse_set_component_table.sv =====
// Testbench for sparse_set_component_table: a directed table, then random lookup,
// emplace and remove words checked against a built-in model of the table.
// Depends on sscomp_pkg and the sparse_set_component_table RTL.
module tb_sparse_set_component_table;
  import sscomp_pkg::*;

  localparam int unsigned ENTITIES = DEF_MAX_ENTITIES;
  localparam int unsigned SLOTS = DEF_CAPACITY;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned PHASE_WORDS = 250;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 16;

  typedef enum int {
    MIX_GROW,
    MIX_CHURN,
    MIX_DRAIN
  } mix_e;

  typedef struct {
    logic [1:0]             mode;
    logic [ENTITY_ID_W-1:0] id;
    logic [DATA_W-1:0]      data;
    bit                     typed;
    res_t                   want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic [1:0]             mode_i;
  logic [ENTITY_ID_W-1:0] entity_id_i;
  logic [DATA_W-1:0]      component_data_i;
  logic                   empty;
  logic                   pop;
  logic [1:0]             status_o;
  logic [DATA_W-1:0]      read_data_o;
  logic [SLOT_OUT_W-1:0]  slot_index_o;
  logic [COUNT_OUT_W-1:0] live_count_o;

  logic                   slot_taken [ENTITIES];
  logic [8:0]             slot_of [ENTITIES];
  logic [DATA_W-1:0]      store_word [SLOTS];
  logic [ENTITY_ID_W-1:0] store_owner [SLOTS];
  int                     stored_total;

  res_t                   pending_q [$];
  res_t                   head_word;
  int                     mismatches;
  int                     quiet_cycles;
  int                     send_idle;
  int                     pop_stall;

  int   send_idle_plan [4] = '{0, 82, 0, 35};
  int   pop_stall_plan [4] = '{0, 0, 82, 35};
  mix_e mix_plan [8] = '{MIX_GROW, MIX_GROW, MIX_CHURN, MIX_DRAIN,
                         MIX_GROW, MIX_CHURN, MIX_DRAIN, MIX_DRAIN};

  dir_row_t dir_rows [22] = '{
    '{MODE_LOOKUP,  10'd0,    64'd0,                  1'b1,
      '{ST_ABSENT, 64'd0, 8'd0, 9'd0}},
    '{MODE_REMOVE,  10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{ST_ABSENT, 64'd0, 8'd0, 9'd0}},
    '{MODE_EMPLACE, 10'd0,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{ST_OK, 64'd0, 8'd0, 9'd1}},
    '{MODE_EMPLACE, 10'd1023, 64'd0,                  1'b1,
      '{ST_OK, 64'd0, 8'd1, 9'd2}},
    '{MODE_EMPLACE, 10'd512,  64'hA5A5_A5A5_A5A5_A5A5, 1'b1,
      '{ST_OK, 64'd0, 8'd2, 9'd3}},
    '{MODE_LOOKUP,  10'd0,    64'd0,                  1'b1,
      '{ST_OK, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 9'd3}},
    '{MODE_SPARE,   10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{ST_OK, 64'd0, 8'd1, 9'd3}},
    '{MODE_EMPLACE, 10'd1023, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0,
      '{ST_OK, 64'd0, 8'd0, 9'd0}},
    '{MODE_LOOKUP,  10'd1023, 64'd0,                  1'b0,
      '{ST_OK, 64'd0, 8'd0, 9'd0}},
    '{MODE_EMPLACE, 10'd0,    64'h0123_4567_89AB_CDEF, 1'b0,
      '{ST_OK, 64'd0, 8'd0, 9'd0}},
    '{MODE_REMOVE,  10'd0,    64'd0,                  1'b1,
      '{ST_OK, 64'd0, 8'd0, 9'd2}},
    '{MODE_LOOKUP,  10'd512,  64'd0,                  1'b0,
      '{ST_OK, 64'd0, 8'd0, 9'd0}},
    '{MODE_LOOKUP,  10'd0,    64'd0,                  1'b1,
      '{ST_ABSENT, 64'd0, 8'd0, 9'd2}},
    '{MODE_REMOVE,  10'd1023, 64'd0,                  1'b1,
      '{ST_OK, 64'd0, 8'd1, 9'd1}},
    '{MODE_REMOVE,  10'd1023, 64'd0,                  1'b1,
      '{ST_ABSENT, 64'd0, 8'd0, 9'd1}},
    '{MODE_SPARE,   10'd1023, 64'd0,                  1'b1,
      '{ST_ABSENT, 64'd0, 8'd0, 9'd1}},
    '{MODE_REMOVE,  10'd512,  64'd0,                  1'b1,
      '{ST_OK, 64'd0, 8'd0, 9'd0}},
    '{MODE_EMPLACE, 10'd341,  64'h8000_0000_0000_0001, 1'b1,
      '{ST_OK, 64'd0, 8'd0, 9'd1}},
    '{MODE_EMPLACE, 10'd682,  64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
      '{ST_OK, 64'd0, 8'd1, 9'd2}},
    '{MODE_REMOVE,  10'd341,  64'd0,                  1'b1,
      '{ST_OK, 64'd0, 8'd0, 9'd1}},
    '{MODE_LOOKUP,  10'd682,  64'd0,                  1'b0,
      '{ST_OK, 64'd0, 8'd0, 9'd0}},
    '{MODE_REMOVE,  10'd682,  64'd0,                  1'b1,
      '{ST_OK, 64'd0, 8'd0, 9'd0}}
  };

  sparse_set_component_table DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .mode_i          (mode_i),
    .entity_id_i     (entity_id_i),
    .component_data_i(component_data_i),
    .empty           (empty),
    .pop             (pop),
    .status_o        (status_o),
    .read_data_o     (read_data_o),
    .slot_index_o    (slot_index_o),
    .live_count_o    (live_count_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic res_t apply_op(logic [1:0] m, logic [ENTITY_ID_W-1:0] id,
                                    logic [DATA_W-1:0] d);
    res_t                   r;
    logic                   hit;
    int                     s;
    int                     last;
    logic [ENTITY_ID_W-1:0] mover;
    r.status     = ST_ABSENT;
    r.read_data  = '0;
    r.slot_index = '0;
    hit = slot_taken[id] && (int'(slot_of[id]) < stored_total);
    s = hit ? int'(slot_of[id]) : 0;
    case (m)
      MODE_EMPLACE: begin
        if (hit) begin
          store_word[s] = d;
          r.status = ST_OK;
          r.slot_index = s[7:0];
        end else if (stored_total >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          s = stored_total;
          store_word[s] = d;
          store_owner[s] = id;
          slot_of[id] = s[8:0];
          slot_taken[id] = 1'b1;
          stored_total = s + 1;
          r.status = ST_OK;
          r.slot_index = s[7:0];
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          last = stored_total - 1;
          if (s != last) begin
            mover = store_owner[last];
            store_word[s] = store_word[last];
            store_owner[s] = mover;
            slot_of[mover] = s[8:0];
          end
          slot_taken[id] = 1'b0;
          slot_of[id] = '0;
          stored_total = last;
          r.status = ST_OK;
          r.slot_index = s[7:0];
        end
      end
      default: begin
        if (hit) begin
          r.status = ST_OK;
          r.read_data = store_word[s];
          r.slot_index = s[7:0];
        end
      end
    endcase
    r.live_count = stored_total[8:0];
    return r;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
    end
    mismatches++;
  endtask

  task automatic send_word(logic [1:0] m, logic [ENTITY_ID_W-1:0] id,
                           logic [DATA_W-1:0] d, bit typed, res_t want);
    res_t got;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    mode_i <= m;
    entity_id_i <= id;
    component_data_i <= d;
    do @(posedge clk_i); while (full);
    got = apply_op(m, id, d);
    pending_q.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_q.size() != 0);
  endtask

  task automatic pick_word(mix_e mix, output logic [1:0] m,
                           output logic [ENTITY_ID_W-1:0] id, output logic [DATA_W-1:0] d);
    int  r;
    int  emplace_cut;
    int  remove_cut;
    r = $urandom_range(99);
    d = {$urandom, $urandom};
    case (mix)
      MIX_GROW: begin
        emplace_cut = 70;
        remove_cut = 80;
      end
      MIX_CHURN: begin
        emplace_cut = 35;
        remove_cut = 70;
      end
      default: begin
        emplace_cut = 10;
        remove_cut = 80;
      end
    endcase
    if (r < emplace_cut) begin
      m = MODE_EMPLACE;
    end else if (r < remove_cut) begin
      m = MODE_REMOVE;
    end else begin
      m = $urandom_range(1) ? MODE_LOOKUP : MODE_SPARE;
    end
    if (m == MODE_EMPLACE) begin
      if (stored_total > 0 && $urandom_range(4) == 0) begin
        id = store_owner[$urandom_range(stored_total - 1)];
      end else if (mix == MIX_CHURN && $urandom_range(1) == 0) begin
        id = ENTITY_ID_W'($urandom_range(31));
      end else begin
        id = ENTITY_ID_W'($urandom_range(ENTITIES - 1));
      end
    end else if (stored_total > 0 && $urandom_range(3) != 0) begin
      id = store_owner[$urandom_range(stored_total - 1)];
    end else begin
      id = ENTITY_ID_W'($urandom_range(ENTITIES - 1));
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      pop <= ($urandom_range(99) >= pop_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_q.size() == 0) begin
        report("unexpected word", {62'd0, status_o}, 64'd0);
      end else begin
        head_word = pending_q.pop_front();
        if (status_o !== head_word.status) begin
          report("status", 64'(status_o), 64'(head_word.status));
        end
        if (read_data_o !== head_word.read_data) begin
          report("read_data", read_data_o, head_word.read_data);
        end
        if (slot_index_o !== head_word.slot_index) begin
          report("slot_index", 64'(slot_index_o), 64'(head_word.slot_index));
        end
        if (live_count_o !== head_word.live_count) begin
          report("live_count", 64'(live_count_o), 64'(head_word.live_count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_sparse_set_component_table: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0]             m;
    logic [ENTITY_ID_W-1:0] id;
    logic [DATA_W-1:0]      d;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    mode_i = MODE_LOOKUP;
    entity_id_i = '0;
    component_data_i = '0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle = 0;
    pop_stall = 0;
    stored_total = 0;
    for (int i = 0; i < ENTITIES; i++) begin
      slot_taken[i] = 1'b0;
      slot_of[i] = '0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].mode, dir_rows[i].id, dir_rows[i].data,
                dir_rows[i].typed, dir_rows[i].want);
    end
    wait_drained();

    foreach (mix_plan[p]) begin
      send_idle = send_idle_plan[p % 4];
      pop_stall = pop_stall_plan[p % 4];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick_word(mix_plan[p], m, id, d);
        send_word(m, id, d, 1'b0, '0);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (pending_q.size() != 0) begin
      report("words never returned", 64'(pending_q.size()), 64'd0);
    end
    if (mismatches == 0) begin
      $display("tb_sparse_set_component_table: clean");
    end else begin
      $display("tb_sparse_set_component_table: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sscomp_pkg.sv
hw/rtl/sscomp_ram.sv
hw/rtl/sscomp_front.sv
hw/rtl/sscomp_back.sv
hw/rtl/sparse_set_component_table.sv
tb/sv/tb_sparse_set_component_table.sv
